[hw/rtl/ntq_pkg.sv]
package ntq_pkg;

	// Ordering policy codes held in the mode register
	localparam logic [1:0] MODE_FCFS = 2'd0;
	localparam logic [1:0] MODE_SJF  = 2'd1;
	localparam logic [1:0] MODE_PRIO = 2'd2;

	// Operation codes of an input word
	localparam logic OP_INSERT   = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	// One queued task as stored in the entry memory
	typedef struct packed {
		logic [7:0] name;
		logic [7:0] duration;
		logic [7:0] prio;
	} entry_t;

	// Result of one item, without the occupancy count
	typedef struct packed {
		logic   served_valid;
		entry_t served;
		logic   insert_rejected;
	} res_t;

endpackage

[hw/rtl/nonpreemptive_task_queue.sv]
// Channel  Handshake               Word
// in       in_valid / in_stall     op, task_name, task_duration, task_priority
// out      out_valid / out_stall   served_*, insert_rejected, queue_count
// cfg      cfg_valid / cfg_ready   cfg_data (order_mode)
//
// One item at a time: in_stall is high from the accept edge until the sequencer is
// back in idle. An empty dispatch or a rejected insert goes straight to the result;
// a dispatch reads the head entry, and a first come first served insert appends at
// the tail. A sorted insert scans through the one read port of the entry memory,
// shifts later entries up unless it lands at the tail, and then writes the entry.
// Reset clears head, count and control state; entries need no clearing pass.
// A result waiting on out_stall holds the sequencer before its return to idle.
module nonpreemptive_task_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] task_name,
	input  logic [7:0] task_duration,
	input  logic [7:0] task_priority,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       served_valid,
	output logic [7:0] served_name,
	output logic [7:0] served_duration,
	output logic [7:0] served_priority,
	output logic       insert_rejected,
	output logic [4:0] queue_count,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic              idle;
	logic              done;
	logic              out_free;
	ntq_pkg::res_t     res;
	ntq_pkg::entry_t   in_entry;
	logic [CW-1:0]     count;
	logic [CW+4:0]     count_ext;
	logic [1:0]        mode_q;
	logic              out_valid_q;
	ntq_pkg::res_t     out_res_q;
	logic [4:0]        out_count_q;

	assign in_entry  = '{name: task_name, duration: task_duration, prio: task_priority};
	assign count_ext = {5'b0, count};

	// Mode register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ntq_pkg::MODE_FCFS;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	ntq_seq #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && !in_stall),
		.op       (op),
		.in_entry (in_entry),
		.mode     (mode_q),
		.out_free (out_free),
		.idle     (idle),
		.done     (done),
		.res      (res),
		.count    (count)
	);

	assign in_stall = !idle;
	assign out_free = !out_valid_q || !out_stall;

	// Output register: load a finished word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_res_q   <= res;
			out_count_q <= count_ext[4:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign served_valid    = out_res_q.served_valid;
	assign served_name     = out_res_q.served.name;
	assign served_duration = out_res_q.served.duration;
	assign served_priority = out_res_q.served.prio;
	assign insert_rejected = out_res_q.insert_rejected;
	assign queue_count     = out_count_q;

endmodule

[hw/rtl/ntq_mem.sv]
module ntq_mem #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output ntq_pkg::entry_t   rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  ntq_pkg::entry_t   wr_data
);

	ntq_pkg::entry_t mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hw/rtl/ntq_seq.sv]
module ntq_seq #(
	parameter int QUEUE_DEPTH = 16,
	localparam int AW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	input  ntq_pkg::entry_t   in_entry,
	input  logic [1:0]        mode,
	input  logic              out_free,
	output logic              idle,
	output logic              done,
	output ntq_pkg::res_t     res,
	output logic [CW-1:0]     count
);

	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] FULL_C  = CW'(QUEUE_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_SHIFT = 6'b000100,
		S_PLACE = 6'b001000,
		S_DISP  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	ntq_pkg::entry_t  item_q;
	logic [7:0]       key_q;
	logic [CW-1:0]    rd_pos_q;
	logic             rd_more_q;
	logic             chk_valid_s1;
	logic [CW-1:0]    chk_pos_s1;
	logic [CW-1:0]    slot_q;
	ntq_pkg::res_t    res_q;

	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	ntq_pkg::entry_t  mem_rdata;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	ntq_pkg::entry_t  mem_wdata;

	logic [7:0]       scan_key;
	logic             scan_hit;
	logic             scan_last;
	logic             sorted;

	// Map a queue position to a memory address behind the head
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
		input logic [AW-1:0] pos);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, pos};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	// Pick the sort key of a task under the current mode
	function automatic logic [7:0] key_of(input ntq_pkg::entry_t e, input logic [1:0] m);
		return (m == ntq_pkg::MODE_SJF) ? e.duration : e.prio;
	endfunction

	ntq_mem #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata)
	);

	assign sorted    = (mode == ntq_pkg::MODE_SJF) || (mode == ntq_pkg::MODE_PRIO);
	assign scan_key  = key_of(mem_rdata, mode);
	assign scan_hit  = (chk_pos_s1 == '0) ? (scan_key > key_q) : (scan_key >= key_q);
	assign scan_last = (chk_pos_s1 == count_q - CW'(1));

	// Drive the memory ports from the current step
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = head_q;
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_wdata = item_q;
		case (state_q)
			S_IDLE: begin
				mem_re = start && (op == ntq_pkg::OP_DISPATCH) && (count_q != '0);
			end
			S_SCAN: begin
				mem_re    = (rd_pos_q < count_q);
				mem_raddr = phys(head_q, rd_pos_q[AW-1:0]);
			end
			S_SHIFT: begin
				mem_re    = rd_more_q;
				mem_raddr = phys(head_q, rd_pos_q[AW-1:0]);
				mem_we    = chk_valid_s1;
				mem_waddr = phys(head_q, chk_pos_s1[AW-1:0] + AW'(1));
				mem_wdata = mem_rdata;
			end
			S_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = phys(head_q, slot_q[AW-1:0]);
			end
			default: ;
		endcase
	end

	// Control state: head, count and the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			chk_valid_s1 <= 1'b0;
			rd_more_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					chk_valid_s1 <= 1'b0;
					if (start) begin
						if (op == ntq_pkg::OP_DISPATCH) begin
							state_q <= (count_q != '0) ? S_DISP : S_EMIT;
						end else if (count_q == FULL_C) begin
							state_q <= S_EMIT;
						end else if (sorted && (count_q != '0)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_PLACE;
						end
					end
				end
				S_SCAN: begin
					if (chk_valid_s1 && (scan_hit || scan_last)) begin
						chk_valid_s1 <= 1'b0;
						rd_more_q    <= 1'b1;
						state_q      <= scan_hit ? S_SHIFT : S_PLACE;
					end else begin
						chk_valid_s1 <= mem_re;
					end
				end
				S_SHIFT: begin
					if (rd_more_q) begin
						rd_more_q <= (rd_pos_q != slot_q);
					end
					if (chk_valid_s1 && (chk_pos_s1 == slot_q)) begin
						chk_valid_s1 <= 1'b0;
						state_q      <= S_PLACE;
					end else begin
						chk_valid_s1 <= rd_more_q;
					end
				end
				S_PLACE: begin
					count_q <= count_q + CW'(1);
					state_q <= S_EMIT;
				end
				S_DISP: begin
					head_q  <= phys(head_q, AW'(1));
					count_q <= count_q - CW'(1);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item payload, scan pointers and the pending result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					item_q   <= in_entry;
					key_q    <= key_of(in_entry, mode);
					rd_pos_q <= '0;
					slot_q   <= count_q;
					res_q    <= '{served_valid: 1'b0, served: '0,
						insert_rejected: (op == ntq_pkg::OP_INSERT) && (count_q == FULL_C)};
				end
			end
			S_SCAN: begin
				chk_pos_s1 <= rd_pos_q;
				if (chk_valid_s1 && (scan_hit || scan_last)) begin
					slot_q   <= scan_hit ? chk_pos_s1 : count_q;
					rd_pos_q <= count_q - CW'(1);
				end else if (mem_re) begin
					rd_pos_q <= rd_pos_q + CW'(1);
				end
			end
			S_SHIFT: begin
				chk_pos_s1 <= rd_pos_q;
				if (rd_more_q && (rd_pos_q != slot_q)) begin
					rd_pos_q <= rd_pos_q - CW'(1);
				end
			end
			S_DISP: begin
				res_q.served_valid <= 1'b1;
				res_q.served       <= mem_rdata;
			end
			default: ;
		endcase
	end

	assign idle  = (state_q == S_IDLE);
	assign done  = (state_q == S_EMIT) && out_free;
	assign res   = res_q;
	assign count = count_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("queue count exceeds depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_re && mem_we && (mem_raddr == mem_waddr)))
		else $error("read and write hit the same entry");

	a_place_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the queue");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == S_IDLE))
		else $error("item accepted while busy");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SHIFT) && chk_valid_s1) |-> (chk_pos_s1 < count_q))
		else $error("shift beyond the tail");
`endif

endmodule
